// ===== hdl/memory_to_memory_alu_assert.svh =====
// Assertion macros used by the RTL in mma_back.
`ifndef MEMORY_TO_MEMORY_ALU_ASSERT_SVH
`define MEMORY_TO_MEMORY_ALU_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/mma_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mma_pkg;

   localparam logic [4:0] OP_LOADIMM = 5'd0;
   localparam logic [4:0] OP_MOVE    = 5'd1;
   localparam logic [4:0] OP_ADD     = 5'd2;
   localparam logic [4:0] OP_SUB     = 5'd3;
   localparam logic [4:0] OP_MUL     = 5'd4;
   localparam logic [4:0] OP_DIV     = 5'd5;
   localparam logic [4:0] OP_MOD     = 5'd6;
   localparam logic [4:0] OP_AND     = 5'd7;
   localparam logic [4:0] OP_OR      = 5'd8;
   localparam logic [4:0] OP_NOT     = 5'd9;
   localparam logic [4:0] OP_XOR     = 5'd10;
   localparam logic [4:0] OP_SHR     = 5'd11;
   localparam logic [4:0] OP_SHL     = 5'd12;
   localparam logic [4:0] OP_EQ      = 5'd13;
   localparam logic [4:0] OP_GT      = 5'd14;
   localparam logic [4:0] OP_LT      = 5'd15;
   localparam logic [4:0] OP_MAX     = 5'd16;
   localparam logic [4:0] OP_MIN     = 5'd17;
   localparam logic [4:0] OP_READ    = 5'd18;
   localparam logic [4:0] OP_WRITE   = 5'd19;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_ADDR     = 3'd1;
   localparam logic [2:0] ERR_DIV_ZERO = 3'd2;
   localparam logic [2:0] ERR_DIV_OVF  = 3'd3;
   localparam logic [2:0] ERR_SHIFT    = 3'd4;

   localparam logic       REG_WORDS_IN_USE = 1'b0;
   localparam logic [8:0] WORDS_RESET      = 9'd256;

   localparam int QUEUE_DEPTH = 2;
   localparam int DIV_STEPS   = 64;

   typedef struct packed {
      logic        [4:0]  operation;
      logic        [7:0]  dest_addr;
      logic        [7:0]  src_addr;
      logic signed [63:0] immediate;
   } req_type;

   typedef struct packed {
      logic signed [63:0] read_data;
      logic               condition;
      logic        [2:0]  error_code;
   } rsp_type;

   typedef struct packed {
      req_type req;
      logic    dest_bad;
      logic    src_bad;
   } work_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_EXEC,
      BK_MUL1,
      BK_MUL2,
      BK_DIV,
      BK_DIV_FIX
   } back_state_type;

endpackage
`default_nettype wire

// ===== hdl/mma_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mma_front #(
   parameter int STORE_WORDS = 256
) (
   input  wire                    start,
   input  mma_pkg::req_type       req_item,
   input  wire  [8:0]             words_in_use,
   input  mma_pkg::q_status_type  q_status,
   input  wire                    clearing,
   output logic                   busy,
   output logic                   push,
   output mma_pkg::work_type      work
);
   import mma_pkg::*;

   logic uses_src;

   function automatic logic addr_ok(input logic [7:0] a, input logic [8:0] limit);
      addr_ok = ({1'b0, a} < limit) && (32'(a) < STORE_WORDS);
   endfunction

   always_comb begin
      uses_src = !(req_item.operation == OP_LOADIMM || req_item.operation == OP_NOT ||
                   req_item.operation >= OP_READ);
      busy          = clearing || q_status.full;
      push          = start && !busy;
      work.req      = req_item;
      work.dest_bad = !addr_ok(req_item.dest_addr, words_in_use);
      work.src_bad  = uses_src && !addr_ok(req_item.src_addr, words_in_use);
   end

endmodule
`default_nettype wire

// ===== hdl/mma_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mma_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  mma_pkg::work_type      push_data,
   input  wire                    pop,
   output mma_pkg::work_type      head,
   output mma_pkg::q_status_type  q_status
);
   import mma_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   work_type        entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
      next_ptr = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(push) - CW'(pop);
      head      = entry_ff[rd_ptr_ff];
      q_status.full  = (count_ff == CW'(QUEUE_DEPTH));
      q_status.empty = (count_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/mma_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mma_back #(
   parameter int STORE_WORDS = 256
) (
   input  wire                    clock,
   input  wire                    reset,
   input  mma_pkg::q_status_type  q_status,
   input  mma_pkg::work_type      q_head,
   output logic                   q_pop,
   output logic                   clearing,
   output logic                   rsp_valid,
   output mma_pkg::rsp_type       rsp_item
);
   import mma_pkg::*;
`include "memory_to_memory_alu_assert.svh"

   localparam int AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
   localparam logic [63:0] MIN_WORD = {1'b1, 63'b0};

   logic [63:0]     mem [STORE_WORDS];

   back_state_type  state_ff, state_in;
   work_type        item_ff, item_in;
   logic [63:0]     x_ff, y_ff;
   logic [63:0]     acc_ff, acc_in;
   logic [31:0]     cross_ff, cross_in;
   logic [63:0]     rem_ff, rem_in;
   logic [63:0]     quo_ff, quo_in;
   logic [63:0]     dvs_ff, dvs_in;
   logic [5:0]      cnt_ff, cnt_in;
   logic [AW-1:0]   clr_ff, clr_in;
   logic            rsp_valid_ff;
   rsp_type         rsp_ff;

   logic            fin;
   logic [63:0]     fin_data;
   logic [2:0]      fin_err;
   logic            wr_en;
   logic [AW-1:0]   wr_idx;
   logic [63:0]     wr_data;

   always_comb begin
      logic [63:0] x;
      logic [63:0] y;
      logic [64:0] shifted;
      logic [64:0] diff;
      logic [63:0] quo_fix;
      logic [63:0] rem_fix;
      logic        do_write;
      x = x_ff;
      y = y_ff;
      shifted  = {rem_ff, quo_ff[63]};
      diff     = shifted - {1'b0, dvs_ff};
      quo_fix  = (x[63] ^ y[63]) ? -quo_ff : quo_ff;
      rem_fix  = x[63] ? -rem_ff : rem_ff;
      do_write = 1'b0;

      state_in = state_ff;
      item_in  = item_ff;
      acc_in   = acc_ff;
      cross_in = cross_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      cnt_in   = cnt_ff;
      clr_in   = clr_ff;
      q_pop    = 1'b0;
      fin      = 1'b0;
      fin_data = x;
      fin_err  = ERR_NONE;
      wr_en    = 1'b0;
      wr_idx   = AW'(item_ff.req.dest_addr);
      wr_data  = fin_data;

      unique case (state_ff)
         BK_CLEAR: begin
            wr_en   = 1'b1;
            wr_idx  = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == AW'(STORE_WORDS - 1)) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (!q_status.empty) begin
               q_pop    = 1'b1;
               item_in  = q_head;
               state_in = BK_EXEC;
            end
         end
         BK_EXEC: begin
            fin = 1'b1;
            priority if (item_ff.dest_bad) begin
               fin_data = '0;
               fin_err  = ERR_ADDR;
            end else if (item_ff.src_bad) begin
               fin_err = ERR_ADDR;
            end else begin
               unique case (item_ff.req.operation)
                  OP_LOADIMM, OP_WRITE: begin
                     fin_data = item_ff.req.immediate;
                     do_write = 1'b1;
                  end
                  OP_MOVE: begin fin_data = y; do_write = 1'b1; end
                  OP_ADD:  begin fin_data = x + y; do_write = 1'b1; end
                  OP_SUB:  begin fin_data = x - y; do_write = 1'b1; end
                  OP_MUL: begin
                     // low partial product now, cross terms in BK_MUL1 and BK_MUL2
                     fin    = 1'b0;
                     acc_in = {32'b0, x[31:0]} * {32'b0, y[31:0]};
                     state_in = BK_MUL1;
                  end
                  OP_DIV, OP_MOD: begin
                     priority if (y == '0) begin
                        fin_err = ERR_DIV_ZERO;
                     end else if (x == MIN_WORD && y == '1) begin
                        fin_err = ERR_DIV_OVF;
                     end else begin
                        fin      = 1'b0;
                        rem_in   = '0;
                        quo_in   = x[63] ? -x : x;
                        dvs_in   = y[63] ? -y : y;
                        cnt_in   = '0;
                        state_in = BK_DIV;
                     end
                  end
                  OP_AND: begin fin_data = x & y; do_write = 1'b1; end
                  OP_OR:  begin fin_data = x | y; do_write = 1'b1; end
                  OP_NOT: begin fin_data = ~x; do_write = 1'b1; end
                  OP_XOR: begin fin_data = x ^ y; do_write = 1'b1; end
                  OP_SHR, OP_SHL: begin
                     if (y > 64'd63) begin
                        fin_err = ERR_SHIFT;
                     end else begin
                        fin_data = (item_ff.req.operation == OP_SHL) ? (x << y[5:0]) :
                                   64'($signed(x) >>> y[5:0]);
                        do_write = 1'b1;
                     end
                  end
                  OP_EQ: begin fin_data = {63'b0, x == y}; do_write = 1'b1; end
                  OP_GT: begin
                     fin_data = {63'b0, $signed(x) > $signed(y)};
                     do_write = 1'b1;
                  end
                  OP_LT: begin
                     fin_data = {63'b0, $signed(x) < $signed(y)};
                     do_write = 1'b1;
                  end
                  OP_MAX: begin
                     fin_data = ($signed(x) > $signed(y)) ? x : y;
                     do_write = 1'b1;
                  end
                  OP_MIN: begin
                     fin_data = ($signed(x) < $signed(y)) ? x : y;
                     do_write = 1'b1;
                  end
                  default: begin
                     fin_data = x;
                  end
               endcase
            end
            if (fin) begin
               state_in = BK_IDLE;
            end
         end
         BK_MUL1: begin
            cross_in = x[31:0] * y[63:32];
            state_in = BK_MUL2;
         end
         BK_MUL2: begin
            fin      = 1'b1;
            fin_data = acc_ff + {cross_ff + x[63:32] * y[31:0], 32'b0};
            do_write = 1'b1;
            state_in = BK_IDLE;
         end
         BK_DIV: begin
            // one restoring step per cycle on magnitudes
            rem_in = diff[64] ? shifted[63:0] : diff[63:0];
            quo_in = {quo_ff[62:0], !diff[64]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'(DIV_STEPS - 1)) begin
               state_in = BK_DIV_FIX;
            end
         end
         BK_DIV_FIX: begin
            fin      = 1'b1;
            fin_data = (item_ff.req.operation == OP_DIV) ? quo_fix : rem_fix;
            do_write = 1'b1;
            state_in = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      if (fin && do_write) begin
         wr_en   = 1'b1;
         wr_data = fin_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= fin;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      acc_ff   <= acc_in;
      cross_ff <= cross_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dvs_ff   <= dvs_in;
      cnt_ff   <= cnt_in;
      rsp_ff.read_data  <= fin_data;
      rsp_ff.condition  <= fin_data[0];
      rsp_ff.error_code <= fin_err;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (q_pop) begin
         x_ff <= mem[AW'(q_head.req.dest_addr)];
         y_ff <= mem[AW'(q_head.req.src_addr)];
      end
   end

   assign clearing  = (state_ff == BK_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid_ff, !rsp_valid_ff)
   `ASSERT_IMPLIES(a_no_pop_in_clear, clock, reset, state_ff == BK_CLEAR, !q_pop && !fin)
   `ASSERT_IMPLIES(a_err_no_write, clock, reset, fin && fin_err != ERR_NONE, !wr_en)
   `ASSERT_NEXT(a_pop_then_exec, clock, reset, q_pop, state_ff == BK_EXEC)

endmodule
`default_nettype wire

// ===== hdl/memory_to_memory_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Two-address ALU over a store of STORE_WORDS signed 64-bit words. A request is
// taken when start is high and busy is low; each request yields one result,
// shown for a single cycle with rsp_valid, and the receiver cannot stall it.
// After reset the store is zeroed word by word with busy high. Requests wait in
// a two-entry queue in front of the execution unit, which reads both operands
// from the store together and mostly writes back in the next cycle; multiply
// goes through BK_MUL1/BK_MUL2 (three 32x32 partial products), divide and modulo
// through BK_DIV (one quotient bit per cycle) and BK_DIV_FIX. Errors leave the
// store unchanged. words_in_use sits at byte address 0 of the csr port.
module memory_to_memory_alu #(
   parameter int STORE_WORDS = 256
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   output logic              busy,
   input  mma_pkg::req_type  req_item,
   output logic              rsp_valid,
   output mma_pkg::rsp_type  rsp_item,
   input  wire               psel,
   input  wire               penable,
   input  wire               pwrite,
   input  wire  [2:0]        paddr,
   input  wire  [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import mma_pkg::*;

   logic [8:0]    words_ff, words_in;
   logic          push;
   logic          pop;
   logic          clearing;
   work_type      work;
   work_type      head;
   q_status_type  q_status;

   always_comb begin
      words_in = words_ff;
      if (psel && penable && pwrite && paddr[2] == REG_WORDS_IN_USE) begin
         words_in = pwdata[8:0];
      end
      prdata = (paddr[2] == REG_WORDS_IN_USE) ? {23'b0, words_ff} : '0;
      pready = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         words_ff <= WORDS_RESET;
      end else begin
         words_ff <= words_in;
      end
   end

   mma_front #(.STORE_WORDS(STORE_WORDS)) u_front (
      .start        (start),
      .req_item     (req_item),
      .words_in_use (words_ff),
      .q_status     (q_status),
      .clearing     (clearing),
      .busy         (busy),
      .push         (push),
      .work         (work)
   );

   mma_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (work),
      .pop       (pop),
      .head      (head),
      .q_status  (q_status)
   );

   mma_back #(.STORE_WORDS(STORE_WORDS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_head    (head),
      .q_pop     (pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule
`default_nettype wire
